/* rtl/pes_header_field_parser_macros.svh */
// Assertion macros for the PES header field parser; they expect clock and reset in scope.
`ifndef PES_HEADER_FIELD_PARSER_MACROS_SVH
`define PES_HEADER_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PHFP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PHFP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/phfp_pkg.sv */
// Types, constants and helper functions shared by the PES header field parser.
`default_nettype none

package phfp_pkg;

   localparam logic [7:0] SID_PRIVATE_1 = 8'hBD;
   localparam logic [7:0] SID_MEDIA_LO  = 8'hC0;
   localparam logic [7:0] SID_MEDIA_HI  = 8'hEF;

   localparam logic [5:0] LEN_SHORT = 6'd6;
   localparam logic [5:0] LEN_BASE  = 6'd9;

   localparam logic [5:0] POS_PREFIX_LAST = 6'd2;
   localparam logic [5:0] POS_STREAM      = 6'd3;
   localparam logic [5:0] POS_LENGTH_LAST = 6'd5;
   localparam logic [5:0] POS_FLAGS       = 6'd7;
   localparam logic [5:0] POS_FIRST_DONE  = 6'd8;
   localparam logic [5:0] POS_PTS_FIRST   = 6'd9;
   localparam logic [5:0] POS_PTS_LAST    = 6'd13;
   localparam logic [5:0] POS_DTS_FIRST   = 6'd14;
   localparam logic [5:0] POS_DTS_LAST    = 6'd18;

   localparam logic [1:0] TS_BOTH = 2'b11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
   } req_item_type;

   typedef struct packed {
      logic [23:0] start_prefix;
      logic [7:0]  stream_kind;
      logic [15:0] packet_length;
      logic [1:0]  timestamp_flags;
      logic [32:0] presentation_stamp;
      logic [32:0] decoding_stamp;
      logic [5:0]  header_bytes;
   } rsp_item_type;

   function automatic logic is_media(input logic [7:0] sid);
      return (sid == SID_PRIVATE_1) || (sid >= SID_MEDIA_LO && sid <= SID_MEDIA_HI);
   endfunction

   // Header length implied by the optional-field flags, without the extension byte.
   function automatic logic [5:0] flag_length(input logic [7:0] b);
      logic [5:0] len;
      len = LEN_BASE;
      if (b[7:6] == TS_BOTH) begin
         len = len + 6'd10;
      end else if (b[7]) begin
         len = len + 6'd5;
      end
      if (b[5]) len = len + 6'd6;
      if (b[4]) len = len + 6'd3;
      if (b[2]) len = len + 6'd1;
      if (b[1]) len = len + 6'd2;
      return len;
   endfunction

   // Extra header bytes announced by the extension flags byte.
   function automatic logic [5:0] extension_length(input logic [7:0] b);
      logic [5:0] len;
      len = 6'd0;
      if (b[7]) len = len + 6'd16;
      if (b[6]) len = len + 6'd1;
      if (b[5]) len = len + 6'd2;
      if (b[4]) len = len + 6'd2;
      if (b[0]) len = len + 6'd2;
      return len;
   endfunction

   // Fold one of the five timestamp bytes into the 33-bit stamp, marker bits dropped.
   function automatic logic [32:0] stamp_next(input logic [32:0] acc, input logic [2:0] idx,
                                              input logic [7:0] b);
      logic [32:0] nxt;
      case (idx)
         3'd0:    nxt = {b[3:1], 30'd0};
         3'd1:    nxt = acc | {3'd0, b, 22'd0};
         3'd2:    nxt = acc | {11'd0, b[7:1], 15'd0};
         3'd3:    nxt = acc | {18'd0, b, 7'd0};
         default: nxt = acc | {26'd0, b[7:1]};
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

/* rtl/phfp_if.sv */
// Request and response channel interfaces of the PES header field parser.
`default_nettype none

interface phfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_start;

   modport source (output valid, output data_byte, output packet_start, input ready);
   modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface phfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] start_prefix;
   logic [7:0]  stream_kind;
   logic [15:0] packet_length;
   logic [1:0]  timestamp_flags;
   logic [32:0] presentation_stamp;
   logic [32:0] decoding_stamp;
   logic [5:0]  header_bytes;

   modport source (output valid, output start_prefix, output stream_kind,
                   output packet_length, output timestamp_flags,
                   output presentation_stamp, output decoding_stamp,
                   output header_bytes, input ready);
   modport sink (input valid, input start_prefix, input stream_kind,
                 input packet_length, input timestamp_flags,
                 input presentation_stamp, input decoding_stamp,
                 input header_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/phfp_in_reg.sv */
// Input register: holds one accepted request until the parser consumes it.
`default_nettype none

module phfp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   phfp_req_if.sink              req_chan,
   input  logic                  advance,
   output logic                  item_valid,
   output phfp_pkg::req_item_type item
);
   import phfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte    <= req_chan.data_byte;
         item_ff.packet_start <= req_chan.packet_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

/* rtl/phfp_track.sv */
// Header tracker: byte position, field captures and running header length.
`default_nettype none

module phfp_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  phfp_pkg::req_item_type item,
   output logic                  hit,
   output phfp_pkg::rsp_item_type result
);
   import phfp_pkg::*;

   logic        collecting_ff, collecting_in;
   logic [5:0]  position_ff, position_in;
   logic [23:0] prefix_ff, prefix_in;
   logic [7:0]  stream_ff, stream_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  flags_ff, flags_in;
   logic [32:0] pts_ff, pts_in;
   logic [32:0] dts_ff, dts_in;
   logic [5:0]  hdr_len_ff, hdr_len_in;
   logic [5:0]  ext_pos_ff, ext_pos_in;

   logic        active;
   logic        media;
   logic [7:0]  b;
   logic [5:0]  pos;
   logic [5:0]  base_len;
   logic [5:0]  pts_off;
   logic [5:0]  dts_off;
   logic [1:0]  ts_flags;

   assign b        = item.data_byte;
   assign base_len = flag_length(item.data_byte);

   always_comb begin
      collecting_in = collecting_ff;
      position_in   = position_ff;
      prefix_in     = prefix_ff;
      stream_in     = stream_ff;
      length_in     = length_ff;
      flags_in      = flags_ff;
      pts_in        = pts_ff;
      dts_in        = dts_ff;
      hdr_len_in    = hdr_len_ff;
      ext_pos_in    = ext_pos_ff;

      // restart the packet on a start byte, even mid-header
      if (fire && item.packet_start) begin
         collecting_in = 1'b1;
         position_in   = '0;
         prefix_in     = '0;
         stream_in     = '0;
         length_in     = '0;
         flags_in      = '0;
         pts_in        = '0;
         dts_in        = '0;
         hdr_len_in    = LEN_SHORT;
         ext_pos_in    = '0;
      end

      active  = fire && collecting_in;
      pos     = position_in;
      pts_off = pos - POS_PTS_FIRST;
      dts_off = pos - POS_DTS_FIRST;

      if (active) begin
         if (pos <= POS_PREFIX_LAST) begin
            prefix_in = {prefix_in[15:0], b};
         end else if (pos == POS_STREAM) begin
            stream_in  = b;
            hdr_len_in = is_media(b) ? LEN_BASE : LEN_SHORT;
         end else if (pos <= POS_LENGTH_LAST) begin
            length_in = {length_in[7:0], b};
         end
      end

      media = is_media(stream_in);

      if (active && media && pos == POS_FLAGS) begin
         flags_in   = b;
         hdr_len_in = base_len + {5'd0, b[0]};
         if (b[0]) begin
            ext_pos_in = base_len;
         end
      end
      if (active && media && pos >= POS_PTS_FIRST && pos <= POS_PTS_LAST) begin
         pts_in = stamp_next(pts_in, pts_off[2:0], b);
      end
      if (active && media && pos >= POS_DTS_FIRST && pos <= POS_DTS_LAST) begin
         dts_in = stamp_next(dts_in, dts_off[2:0], b);
      end
      // extension flags byte: its position is only known once byte 7 is in
      if (active && media && pos > POS_FLAGS && flags_in[0] && pos == ext_pos_in) begin
         hdr_len_in = hdr_len_in + extension_length(b);
      end

      hit = active && (({1'b0, pos} + 7'd1) == {1'b0, hdr_len_in})
            && (!media || pos >= POS_FIRST_DONE);

      if (active) begin
         if (hit) begin
            collecting_in = 1'b0;
         end else begin
            position_in = pos + 6'd1;
         end
      end

      ts_flags                  = media ? flags_in[7:6] : 2'b00;
      result.start_prefix       = prefix_in;
      result.stream_kind        = stream_in;
      result.packet_length      = length_in;
      result.timestamp_flags    = ts_flags;
      result.presentation_stamp = ts_flags[1] ? pts_in : '0;
      result.decoding_stamp     = (ts_flags == TS_BOTH) ? dts_in : '0;
      result.header_bytes       = hdr_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
      end
   end

   always_ff @(posedge clock) begin
      position_ff <= position_in;
      prefix_ff   <= prefix_in;
      stream_ff   <= stream_in;
      length_ff   <= length_in;
      flags_ff    <= flags_in;
      pts_ff      <= pts_in;
      dts_ff      <= dts_in;
      hdr_len_ff  <= hdr_len_in;
      ext_pos_ff  <= ext_pos_in;
   end

endmodule

`default_nettype wire

/* rtl/phfp_out_reg.sv */
// Output register: holds a finished header result until the sink takes it.
`default_nettype none

module phfp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  phfp_pkg::rsp_item_type result,
   output logic                  free,
   phfp_rsp_if.source            rsp_chan
);
   import phfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid              = valid_ff;
   assign rsp_chan.start_prefix       = result_ff.start_prefix;
   assign rsp_chan.stream_kind        = result_ff.stream_kind;
   assign rsp_chan.packet_length      = result_ff.packet_length;
   assign rsp_chan.timestamp_flags    = result_ff.timestamp_flags;
   assign rsp_chan.presentation_stamp = result_ff.presentation_stamp;
   assign rsp_chan.decoding_stamp     = result_ff.decoding_stamp;
   assign rsp_chan.header_bytes       = result_ff.header_bytes;

endmodule

`default_nettype wire

/* rtl/pes_header_field_parser.sv */
// Top level of the PES header field parser.
//
// req_chan carries a PES packet one byte per request; packet_start marks byte 0.
// rsp_chan carries one result per packet header: start code prefix, stream id,
// packet length, PTS/DTS flags, both 33-bit stamps (zero when absent) and the
// computed header length. Bytes that arrive outside a header are dropped.
// A request is registered on acceptance and parsed once the output register is
// free; the result of the last header byte is registered in the output register
// and presented on rsp_chan from there until the sink takes it. One byte per
// cycle is sustained while the sink does not stall: the parser state updates
// from the input register straight into the output register.
// When the sink stalls, the finished result holds in the output register and
// one further request is still taken into the input register; req_chan.ready
// then drops until the sink takes the result.
// Reset (synchronous, active high) empties both registers and leaves the parser
// idle until the next packet_start; no clearing pass is needed.
`default_nettype none

`include "pes_header_field_parser_macros.svh"

module pes_header_field_parser (
   input  logic        clock,
   input  logic        reset,
   phfp_req_if.sink    req_chan,
   phfp_rsp_if.source  rsp_chan
);
   import phfp_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         out_free;
   logic         fire;
   logic         hit;
   rsp_item_type result;

   assign fire = item_valid && out_free;

   phfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   phfp_track u_track (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .hit    (hit),
      .result (result)
   );

   phfp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (fire && hit),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   `PHFP_ASSERT_NXT(a_hit_shows, fire && hit, rsp_chan.valid, "header result was not presented")
   `PHFP_ASSERT_IMP(a_len_floor, rsp_chan.valid, rsp_chan.header_bytes >= LEN_SHORT, "header length below six")
   `PHFP_ASSERT_IMP(a_pts_zero, rsp_chan.valid && !rsp_chan.timestamp_flags[1], rsp_chan.presentation_stamp == '0, "PTS set without PTS flag")
   `PHFP_ASSERT_IMP(a_short_hdr, rsp_chan.valid && !is_media(rsp_chan.stream_kind), rsp_chan.header_bytes == LEN_SHORT && rsp_chan.timestamp_flags == 2'b00, "non-media header not six bytes")

endmodule

`default_nettype wire
